FILE: hdl/keyed_entry_table_with_aging_core_defines.svh
`ifndef KEYED_ENTRY_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_WITH_AGING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define KETE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define KETE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/kete_pkg.sv
// ----------------------------------------------------------------------------
// kete_pkg
// Shared codes, widths and control types of the keyed entry table.
// ----------------------------------------------------------------------------
`default_nettype none

package kete_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 16;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 8;
  localparam int STAMP_W = 32;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd120;

  localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LISTED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

  typedef struct packed {
    logic cap;   // capture request
    logic scan;  // run the slot scan
    logic act;   // apply result and load response
  } kete_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic total_zero;
  } kete_sts_t;

endpackage

`default_nettype wire

FILE: hdl/kete_ram.sv
// ----------------------------------------------------------------------------
// kete_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module kete_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kete_ctrl.sv
// ----------------------------------------------------------------------------
// kete_ctrl
// Request sequencer: accept, scan the table, then apply and respond.
// ----------------------------------------------------------------------------
`default_nettype none

module kete_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [kete_pkg::MODE_W-1:0] in_mode,
  input  wire kete_pkg::kete_sts_t        sts,
  output kete_pkg::kete_cmd_t             cmd
);

  import kete_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [MODE_W-1:0] mode_q;
  logic              accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.cap = 1'b1;
          unique case (in_mode)
            MODE_REGISTER, MODE_UNREGISTER, MODE_UPDATE, MODE_TICK: begin
              state_next = S_SCAN;
            end
            MODE_QUERY: begin
              state_next = sts.total_zero ? S_FINISH : S_SCAN;
            end
            default: begin
              state_next = S_IDLE;  // drop unused modes
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = (mode_q == MODE_QUERY) ? S_IDLE : S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.act    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= in_mode;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kete_dp.sv
// ----------------------------------------------------------------------------
// kete_dp
// Table storage, slot scan pipeline, aging and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module kete_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire kete_pkg::kete_cmd_t             cmd,
  output kete_pkg::kete_sts_t                  sts,
  input  wire logic [kete_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [kete_pkg::KEY_W-1:0]      in_key,
  input  wire logic [kete_pkg::VALUE_W-1:0]    in_value,
  input  wire logic                            cfg_wen,
  input  wire logic [kete_pkg::TIMEOUT_W-1:0]  cfg_wdata,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [kete_pkg::STAT_W-1:0]          out_status,
  output logic [kete_pkg::SLOT_W-1:0]          out_slot,
  output logic [kete_pkg::KEY_W-1:0]           out_key,
  output logic [kete_pkg::VALUE_W-1:0]         out_port,
  output logic [kete_pkg::VALUE_W-1:0]         out_players,
  output logic [kete_pkg::COUNT_W-1:0]         out_count,
  output logic                                 out_last
);

  import kete_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // request and table-wide state
  logic [MODE_W-1:0]      mode_q;
  logic [KEY_W-1:0]       key_q;
  logic [VALUE_W-1:0]     value_q;
  logic [STAMP_W-1:0]     seconds;
  logic [TIMEOUT_W-1:0]   timeout;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          total;
  logic [CW-1:0]          total_next;

  // scan pipeline
  logic [CW-1:0] scan_cnt;
  logic          s1_valid;
  logic [IW-1:0] s1_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] listed;

  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_port;
  logic [VALUE_W-1:0] rd_players;
  logic [STAMP_W-1:0] rd_stamp;

  logic               out_free;
  logic               issue;
  logic               adv;
  logic               re;
  logic               s1_live;
  logic               slot_on;
  logic [STAMP_W-1:0] age;
  logic               expired;
  logic               key_match;
  logic               list_load;
  logic               list_last;
  logic               tick_clear;

  // finish-stage controls
  logic               we_key;
  logic               we_port;
  logic               we_players;
  logic               we_stamp;
  logic [IW-1:0]      fin_addr;
  logic               fin_set;
  logic               fin_clr;
  logic [STAT_W-1:0]  fin_status;
  logic [VALUE_W-1:0] players_wdata;

  assign out_free  = !out_valid || out_ready;
  assign issue     = (scan_cnt != CW'(TABLE_DEPTH));
  assign adv       = cmd.scan && ((mode_q != MODE_QUERY) || out_free);
  assign re        = adv && issue;
  assign s1_live   = adv && s1_valid;
  assign slot_on   = valid[s1_idx];
  assign age       = seconds - rd_stamp;
  assign expired   = slot_on && (age > {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout});
  assign key_match = slot_on && (rd_key == key_q);
  assign list_load = s1_live && (mode_q == MODE_QUERY) && slot_on;
  assign list_last = ((listed + CW'(1)) == total);
  assign tick_clear = s1_live && (mode_q == MODE_TICK) && expired;

  assign players_wdata = (mode_q == MODE_UPDATE) ? value_q : VALUE_W'(1);

  assign sts.scan_done  = !s1_valid && !issue;
  assign sts.out_free   = out_free;
  assign sts.total_zero = (total == '0);

  always_comb begin
    we_key     = 1'b0;
    we_port    = 1'b0;
    we_players = 1'b0;
    we_stamp   = 1'b0;
    fin_addr   = hit_idx;
    fin_set    = 1'b0;
    fin_clr    = 1'b0;
    fin_status = STAT_DONE;
    if (cmd.act) begin
      unique case (mode_q)
        MODE_REGISTER: begin
          if (hit) begin
            we_port  = 1'b1;
            we_stamp = 1'b1;
          end else if (free_found) begin
            fin_addr   = free_idx;
            we_key     = 1'b1;
            we_port    = 1'b1;
            we_players = 1'b1;
            we_stamp   = 1'b1;
            fin_set    = 1'b1;
          end else begin
            fin_status = STAT_FULL;
          end
        end
        MODE_UNREGISTER: begin
          if (hit) begin
            fin_clr = 1'b1;
          end else begin
            fin_status = STAT_NOT_FOUND;
          end
        end
        MODE_UPDATE: begin
          if (hit) begin
            we_players = 1'b1;
            we_stamp   = 1'b1;
          end else begin
            fin_status = STAT_NOT_FOUND;
          end
        end
        MODE_QUERY: begin
          fin_status = STAT_EMPTY;
        end
        default: begin
          fin_status = STAT_DONE;  // tick
        end
      endcase
    end
  end

  always_comb begin
    total_next = total;
    if (tick_clear || fin_clr) begin
      total_next = total - CW'(1);
    end else if (fin_set) begin
      total_next = total + CW'(1);
    end
  end

  kete_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (we_key),
    .waddr (fin_addr),
    .wdata (key_q),
    .re    (re),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (rd_key)
  );

  kete_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_port_ram (
    .clk   (clk),
    .we    (we_port),
    .waddr (fin_addr),
    .wdata (value_q),
    .re    (re),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (rd_port)
  );

  kete_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_players_ram (
    .clk   (clk),
    .we    (we_players),
    .waddr (fin_addr),
    .wdata (players_wdata),
    .re    (re),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (rd_players)
  );

  kete_ram #(.WIDTH(STAMP_W), .DEPTH(TABLE_DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (we_stamp),
    .waddr (fin_addr),
    .wdata (seconds),
    .re    (re),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (rd_stamp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds    <= '0;
      timeout    <= TIMEOUT_RESET;
      valid      <= '0;
      total      <= '0;
      scan_cnt   <= '0;
      s1_valid   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      listed     <= '0;
      out_valid  <= 1'b0;
    end else begin
      total <= total_next;
      if (cfg_wen) begin
        timeout <= cfg_wdata;
      end
      if (cmd.cap) begin
        scan_cnt   <= '0;
        s1_valid   <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        listed     <= '0;
        if (in_mode == MODE_TICK) begin
          seconds <= seconds + STAMP_W'(1);
        end
      end
      if (adv) begin
        s1_valid <= issue;
        if (issue) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
      end
      if (s1_live && key_match && !hit) begin
        hit <= 1'b1;
      end
      if (s1_live && !slot_on && !free_found) begin
        free_found <= 1'b1;
      end
      if (list_load) begin
        listed <= listed + CW'(1);
      end
      if (tick_clear) begin
        valid[s1_idx] <= 1'b0;
      end
      if (fin_set) begin
        valid[fin_addr] <= 1'b1;
      end
      if (fin_clr) begin
        valid[fin_addr] <= 1'b0;
      end
      if (list_load || cmd.act) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_q  <= in_mode;
      key_q   <= in_key;
      value_q <= in_value;
    end
    if (adv) begin
      s1_idx <= scan_cnt[IW-1:0];
    end
    if (s1_live && key_match && !hit) begin
      hit_idx <= s1_idx;
    end
    if (s1_live && !slot_on && !free_found) begin
      free_idx <= s1_idx;
    end
    if (list_load) begin
      out_status  <= STAT_LISTED;
      out_slot    <= SLOT_W'(s1_idx);
      out_key     <= rd_key;
      out_port    <= rd_port;
      out_players <= rd_players;
      out_count   <= COUNT_W'(total);
      out_last    <= list_last;
    end else if (cmd.act) begin
      out_status  <= fin_status;
      out_slot    <= (fin_set || fin_clr || we_stamp) ? SLOT_W'(fin_addr) : '0;
      out_key     <= '0;
      out_port    <= '0;
      out_players <= '0;
      out_count   <= COUNT_W'(total_next);  // never above the table depth
      out_last    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/keyed_entry_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// keyed_entry_table_with_aging_core
// Keyed client table with register, unregister, update, listing and aging.
// ----------------------------------------------------------------------------
// Requests arrive on s_axis: tuser carries the mode, tdata the client key and
// the request value. Responses leave on m_axis: tuser carries the status,
// tlast marks the final response of a request. The user must write the timeout
// through cfg_wen/cfg_wdata only while the block is idle; the block itself does
// not enforce this. The timeout resets to 120 ticks. Each register, unregister,
// update, tick or non-empty query walks every slot of the key/port/players/stamp
// RAMs, one slot per cycle through a one-deep read pipeline; a query walk pauses
// while m_axis stalls. For a register, unregister, update or tick, tready returns
// in the cycle that its response appears, so such a request is finished before
// the next is taken. A query emits one response per valid slot during its walk.
// Requests with unused modes are taken and give no response.
// Reset clears the valid bits, the entry count and the seconds counter at once;
// there is no clearing pass. When m_axis stalls, a listing walk pauses with
// the pending entry held, and other requests hold their response until it is
// taken; s_axis tready stays low until the request is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_entry_table_with_aging_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // client_key[31:0], request_value[47:32]
  input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot_index[5:0], entry_key[37:6], entry_port[53:38], entry_players[69:54],
  // listed_count[77:70], zero[79:78]
  output logic [79:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,  // status[2:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata
);

  import kete_pkg::*;

  kete_cmd_t cmd;
  kete_sts_t sts;

  logic [SLOT_W-1:0]  out_slot;
  logic [KEY_W-1:0]   out_key;
  logic [VALUE_W-1:0] out_port;
  logic [VALUE_W-1:0] out_players;
  logic [COUNT_W-1:0] out_count;

  kete_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  kete_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (s_axis_tuser),
    .in_key      (s_axis_tdata[31:0]),
    .in_value    (s_axis_tdata[47:32]),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_status  (m_axis_tuser),
    .out_slot    (out_slot),
    .out_key     (out_key),
    .out_port    (out_port),
    .out_players (out_players),
    .out_count   (out_count),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_count, out_players, out_port, out_key, out_slot};

endmodule

`default_nettype wire

FILE: hdl/kete_checker.sv
// ----------------------------------------------------------------------------
// kete_checker
// Port-level checks of the keyed entry table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_entry_table_with_aging_core_defines.svh"

module kete_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  import kete_pkg::*;

  // hold a stalled response
  `KETE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled response changed")

  // every response other than a listed entry ends its request
  `KETE_ASSERT_NOW(a_single_last, m_axis_tvalid && (m_axis_tuser != STAT_LISTED), m_axis_tlast, "non-listing response without tlast")

  // entry contents only travel with a listed entry
  `KETE_ASSERT_NOW(a_zero_payload, m_axis_tvalid && (m_axis_tuser != STAT_LISTED), m_axis_tdata[69:6] == '0, "entry fields set on a non-listing response")

  // the entry count never exceeds the table depth
  `KETE_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[77:70] <= 8'(TABLE_DEPTH), "entry count beyond table depth")

  // drop ready once a request with a defined mode is taken
  `KETE_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready && (s_axis_tuser <= MODE_TICK), !s_axis_tready, "ready held after a request was taken")

endmodule

bind keyed_entry_table_with_aging_core kete_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
